### rtl/lfps_pkg.sv
`timescale 1ns / 1ps

package lfps_pkg;

   // field and datapath widths
   localparam int LIGHT_W     = 8;
   localparam int ACTION_W    = 2;
   localparam int POWER_W     = 8;
   localparam int GAIN_W      = 16;
   localparam int ERR_W       = 10;
   localparam int DIFF_W      = 11;
   localparam int FRAC_W      = 8;
   localparam int MEAN_W      = 18;
   localparam int MULA_W      = 16;
   localparam int MULB_W      = 18;
   localparam int PROD_W      = MULA_W + MULB_W;
   localparam int ACC_W       = PROD_W + FRAC_W + 2;
   localparam int STEER_SHIFT = 16;
   localparam int STEP_W      = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // fixed constants of the control law
   localparam int POWER_MAX    = 100;
   localparam int STEER_LIMIT  = 100;
   localparam int RAMP_START   = 50;
   localparam int RAMP_FULL_MS = 1000;
   localparam int ROUND_BIAS   = (1 << STEER_SHIFT) - 1;
   // x / 100 as (x * 5243) >> 19, exact for x below 2^15
   localparam int RECIP_100    = 5243;
   localparam int RECIP_SHIFT  = 19;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STOP   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PROP_GAIN        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INTEG_GAIN       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DERIV_GAIN       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LIGHT_CENTER     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FOLLOW_LEFT_EDGE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_POWER       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_STEER_OFFSET     = 3'd6;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic signed [GAIN_W-1:0] deriv_gain;
      logic [LIGHT_W-1:0]       light_center;
      logic                     follow_left_edge;
      logic [POWER_W-2:0]       base_power;
      logic signed [POWER_W-1:0] steer_offset;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      prop_gain:        16'sd0,
      integ_gain:       16'sd0,
      deriv_gain:       16'sd0,
      light_center:     8'd128,
      follow_left_edge: 1'b1,
      base_power:       7'd0,
      steer_offset:     8'sd0
   };

   // datapath operations, one per microcode step
   typedef enum logic [3:0] {
      OP_NONE,
      OP_ERR,
      OP_PUSH,
      OP_DIV_INIT,
      OP_MUL_P,
      OP_MUL_I,
      OP_MUL_D,
      OP_ACC_D,
      OP_STEER,
      OP_MUL_PWR,
      OP_MUL_RCP,
      OP_EMIT,
      OP_CLEAR,
      OP_STOP
   } op_type;

   // sequencer branch conditions
   typedef enum logic [2:0] {
      C_NEXT,
      C_GOTO,
      C_DISPATCH,
      C_LOOP_DIV,
      C_WAIT_OUT
   } cond_type;

   typedef struct packed {
      op_type             op;
      cond_type           cond;
      logic [STEP_W-1:0]  target;
   } ucode_type;

   typedef struct packed {
      logic                accept;
      logic [ACTION_W-1:0] action;
      logic                div_busy;
      logic                out_free;
   } seq_cond_type;

   // program addresses
   localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_ERR       = 4'd1;
   localparam logic [STEP_W-1:0] STEP_PUSH      = 4'd2;
   localparam logic [STEP_W-1:0] STEP_DIV_START = 4'd3;
   localparam logic [STEP_W-1:0] STEP_DIV_WAIT  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MUL_P     = 4'd5;
   localparam logic [STEP_W-1:0] STEP_MUL_I     = 4'd6;
   localparam logic [STEP_W-1:0] STEP_MUL_D     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_ACC_D     = 4'd8;
   localparam logic [STEP_W-1:0] STEP_STEER     = 4'd9;
   localparam logic [STEP_W-1:0] STEP_MUL_PWR   = 4'd10;
   localparam logic [STEP_W-1:0] STEP_MUL_RCP   = 4'd11;
   localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd12;
   localparam logic [STEP_W-1:0] STEP_CLEAR     = 4'd13;
   localparam logic [STEP_W-1:0] STEP_STOP      = 4'd14;

   // control store
   function automatic ucode_type microcode_rom(input logic [STEP_W-1:0] step);
      ucode_type uc;
      uc = '{op: OP_NONE, cond: C_GOTO, target: STEP_IDLE};
      case (step)
         STEP_IDLE:      uc = '{op: OP_NONE,     cond: C_DISPATCH, target: STEP_IDLE};
         STEP_ERR:       uc = '{op: OP_ERR,      cond: C_NEXT,     target: STEP_IDLE};
         STEP_PUSH:      uc = '{op: OP_PUSH,     cond: C_NEXT,     target: STEP_IDLE};
         STEP_DIV_START: uc = '{op: OP_DIV_INIT, cond: C_NEXT,     target: STEP_IDLE};
         STEP_DIV_WAIT:  uc = '{op: OP_NONE,     cond: C_LOOP_DIV, target: STEP_IDLE};
         STEP_MUL_P:     uc = '{op: OP_MUL_P,    cond: C_NEXT,     target: STEP_IDLE};
         STEP_MUL_I:     uc = '{op: OP_MUL_I,    cond: C_NEXT,     target: STEP_IDLE};
         STEP_MUL_D:     uc = '{op: OP_MUL_D,    cond: C_NEXT,     target: STEP_IDLE};
         STEP_ACC_D:     uc = '{op: OP_ACC_D,    cond: C_NEXT,     target: STEP_IDLE};
         STEP_STEER:     uc = '{op: OP_STEER,    cond: C_NEXT,     target: STEP_IDLE};
         STEP_MUL_PWR:   uc = '{op: OP_MUL_PWR,  cond: C_NEXT,     target: STEP_IDLE};
         STEP_MUL_RCP:   uc = '{op: OP_MUL_RCP,  cond: C_NEXT,     target: STEP_IDLE};
         STEP_EMIT:      uc = '{op: OP_EMIT,     cond: C_WAIT_OUT, target: STEP_IDLE};
         STEP_CLEAR:     uc = '{op: OP_CLEAR,    cond: C_GOTO,     target: STEP_IDLE};
         STEP_STOP:      uc = '{op: OP_STOP,     cond: C_WAIT_OUT, target: STEP_IDLE};
         default:        uc = '{op: OP_NONE,     cond: C_GOTO,     target: STEP_IDLE};
      endcase
      return uc;
   endfunction

endpackage

### rtl/lfps_req_if.sv
`timescale 1ns / 1ps

interface lfps_req_if;
   logic                                valid;
   logic                                ready;
   logic [lfps_pkg::ACTION_W-1:0]       action;
   logic [lfps_pkg::LIGHT_W-1:0]        reflect_light;

   modport source (output valid, action, reflect_light, input ready);
   modport sink   (input valid, action, reflect_light, output ready);
endinterface

### rtl/lfps_rsp_if.sv
`timescale 1ns / 1ps

interface lfps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [lfps_pkg::POWER_W-1:0] left_power;
   logic signed [lfps_pkg::POWER_W-1:0] right_power;

   modport source (output valid, left_power, right_power, input ready);
   modport sink   (input valid, left_power, right_power, output ready);
endinterface

### rtl/line_follow_pid_steering_top.sv
`timescale 1ns / 1ps
// control sample: error, history push, divider loop for the window mean, then the
// PID products, steering, ramp power scaling and emit steps; the result is registered
// once the output register is free, and the next transaction is taken after that
// clear: no result; stop: result with zero powers registered once the output is free
// one transaction at a time: the input is taken only while the sequencer is idle
// reset is synchronous, active high: registers to defaults, empty history, ramp at zero

module line_follow_pid_steering_top #(
   parameter int WINDOW_LEN       = 5,
   parameter int SAMPLE_PERIOD_MS = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [lfps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lfps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   lfps_req_if.sink                             req_bus,
   lfps_rsp_if.source                           rsp_bus
);

   lfps_pkg::cfg_type      cfg_ff, cfg_in;
   lfps_pkg::ucode_type    ctrl;
   lfps_pkg::seq_cond_type seq_cond;
   logic                   seq_idle;
   logic                   accept;
   logic                   div_busy;
   logic                   out_free;
   logic                   out_load;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [lfps_pkg::POWER_W-1:0] left_ff, right_ff;
   logic signed [lfps_pkg::POWER_W-1:0] dp_left, dp_right;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lfps_pkg::REG_PROP_GAIN:        cfg_in.prop_gain = $signed(csr_wdata);
            lfps_pkg::REG_INTEG_GAIN:       cfg_in.integ_gain = $signed(csr_wdata);
            lfps_pkg::REG_DERIV_GAIN:       cfg_in.deriv_gain = $signed(csr_wdata);
            lfps_pkg::REG_LIGHT_CENTER:     cfg_in.light_center = csr_wdata[7:0];
            lfps_pkg::REG_FOLLOW_LEFT_EDGE: cfg_in.follow_left_edge = csr_wdata[0];
            lfps_pkg::REG_BASE_POWER:       cfg_in.base_power = csr_wdata[6:0];
            lfps_pkg::REG_STEER_OFFSET:     cfg_in.steer_offset = $signed(csr_wdata[7:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= lfps_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input handshake
   assign req_bus.ready = seq_idle;
   assign accept        = req_bus.valid && seq_idle;

   // output register
   assign out_free     = !rsp_valid_ff || rsp_bus.ready;
   assign out_load     = out_free &&
                         (ctrl.op == lfps_pkg::OP_EMIT || ctrl.op == lfps_pkg::OP_STOP);
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         left_ff  <= dp_left;
         right_ff <= dp_right;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.left_power  = left_ff;
   assign rsp_bus.right_power = right_ff;

   // sequencer branch inputs
   assign seq_cond = '{accept:   accept,
                       action:   req_bus.action,
                       div_busy: div_busy,
                       out_free: out_free};

   lfps_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .cond  (seq_cond),
      .ctrl  (ctrl),
      .idle  (seq_idle)
   );

   lfps_datapath #(
      .WINDOW_LEN       (WINDOW_LEN),
      .SAMPLE_PERIOD_MS (SAMPLE_PERIOD_MS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .cfg           (cfg_ff),
      .accept        (accept),
      .reflect_light (req_bus.reflect_light),
      .div_busy      (div_busy),
      .left_power    (dp_left),
      .right_power   (dp_right)
   );

endmodule

### rtl/lfps_divider.sv
`timescale 1ns / 1ps

module lfps_divider #(
   parameter int DVD_W = 21,
   parameter int DIV_W = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             busy,
   output logic [DVD_W-1:0] quotient
);

   localparam int ITER_W = $clog2(DVD_W + 1);

   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dsr_ff, dsr_in;
   logic [DIV_W:0]    rem_sh;
   logic [DIV_W:0]    rem_diff;
   logic              fits;

   assign busy     = (iter_ff != '0);
   assign quotient = quo_ff;

   // one restoring step per cycle, quotient bits shift in from the bottom
   assign rem_sh   = {rem_ff, quo_ff[DVD_W-1]};
   assign rem_diff = rem_sh - {1'b0, dsr_ff};
   assign fits     = (rem_sh >= {1'b0, dsr_ff});

   always_comb begin
      iter_in = iter_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         iter_in = ITER_W'(DVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy) begin
         iter_in = iter_ff - ITER_W'(1);
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         rem_in  = fits ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
      end else begin
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

endmodule

### rtl/lfps_datapath.sv
`timescale 1ns / 1ps

module lfps_datapath #(
   parameter int WINDOW_LEN       = 5,
   parameter int SAMPLE_PERIOD_MS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lfps_pkg::ucode_type                 ctrl,
   input  lfps_pkg::cfg_type                   cfg,
   input  logic                                accept,
   input  logic [lfps_pkg::LIGHT_W-1:0]        reflect_light,
   output logic                                div_busy,
   output logic signed [lfps_pkg::POWER_W-1:0] left_power,
   output logic signed [lfps_pkg::POWER_W-1:0] right_power
);

   localparam int ERR_W     = lfps_pkg::ERR_W;
   localparam int DIFF_W    = lfps_pkg::DIFF_W;
   localparam int MEAN_W    = lfps_pkg::MEAN_W;
   localparam int MULA_W    = lfps_pkg::MULA_W;
   localparam int MULB_W    = lfps_pkg::MULB_W;
   localparam int PROD_W    = lfps_pkg::PROD_W;
   localparam int ACC_W     = lfps_pkg::ACC_W;
   localparam int POWER_W   = lfps_pkg::POWER_W;
   localparam int SHIFT     = lfps_pkg::STEER_SHIFT;
   localparam int SQ_W      = ACC_W - SHIFT + 1;
   localparam int CNT_W     = $clog2(WINDOW_LEN + 1);
   localparam int PTR_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int SUM_W     = ERR_W + $clog2(WINDOW_LEN);
   localparam int DVD_W     = SUM_W + lfps_pkg::FRAC_W;
   localparam int RAMP_STEP = SAMPLE_PERIOD_MS * lfps_pkg::POWER_MAX / lfps_pkg::RAMP_FULL_MS;

   logic [lfps_pkg::LIGHT_W-1:0] light_ff;
   logic signed [ERR_W-1:0]      err_ff, err_in;
   logic signed [ERR_W-1:0]      prev_ff, prev_in;
   logic signed [ERR_W-1:0]      oldest_ff;
   logic signed [ERR_W-1:0]      hist [WINDOW_LEN];
   logic                         hist_we;
   logic signed [ERR_W-1:0]      hist_wdata;
   logic [PTR_W-1:0]             wptr_ff, wptr_in, wptr_next;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         full;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic signed [SUM_W-1:0]      oldest_term;
   logic [SUM_W-1:0]             sum_mag;
   logic                         neg_ff, neg_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [ACC_W-1:0]      prod_sh, prod_ext, acc_round;
   logic signed [SQ_W-1:0]       steer_sum;
   logic signed [POWER_W-1:0]    steer_ff, steer_in;
   logic [POWER_W-2:0]           ramp_ff, ramp_in;
   logic [POWER_W-2:0]           base, ramp_lift, ramp_next;
   logic [POWER_W-1:0]           ramp_step;
   logic signed [ERR_W-1:0]      light_ext, center_ext, err_calc;
   logic signed [DIFF_W-1:0]     diff;
   logic signed [MEAN_W-1:0]     mean_mag, mean8;
   logic signed [POWER_W:0]      scale_k;
   logic signed [MULA_W-1:0]     mul_a;
   logic signed [MULB_W-1:0]     mul_b;
   logic signed [PROD_W-1:0]     mul_p;
   logic                         mul_en;
   logic [DVD_W-1:0]             quotient;
   logic signed [POWER_W-1:0]    scaled_pwr, ramp_pwr;

   // window mean divider
   lfps_divider #(
      .DVD_W (DVD_W),
      .DIV_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.op == lfps_pkg::OP_DIV_INIT),
      .dividend ({sum_mag, 8'h00}),
      .divisor  (count_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // edge error and error difference
   assign light_ext  = $signed({2'b00, light_ff});
   assign center_ext = $signed({2'b00, cfg.light_center});
   assign err_calc   = cfg.follow_left_edge ? (light_ext - center_ext) : (center_ext - light_ext);
   assign diff       = DIFF_W'(err_ff) - DIFF_W'(prev_ff);

   // history bookkeeping, circular with the oldest entry at the write pointer
   assign full        = (count_ff == CNT_W'(WINDOW_LEN));
   assign wptr_next   = (wptr_ff == PTR_W'(WINDOW_LEN - 1)) ? '0 : wptr_ff + PTR_W'(1);
   assign oldest_term = full ? SUM_W'(oldest_ff) : SUM_W'(0);
   assign sum_mag     = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   // signed window mean with 8 fraction bits
   assign mean_mag = $signed(quotient[MEAN_W-1:0]);
   assign mean8    = neg_ff ? -mean_mag : mean_mag;

   // steering sum, truncated toward zero, plus offset
   assign prod_ext  = ACC_W'(prod_ff);
   assign prod_sh   = prod_ext <<< lfps_pkg::FRAC_W;
   assign acc_round = acc_ff + (acc_ff[ACC_W-1] ? ACC_W'(lfps_pkg::ROUND_BIAS) : ACC_W'(0));
   assign steer_sum = SQ_W'($signed(acc_round[ACC_W-1:SHIFT])) + SQ_W'(cfg.steer_offset);

   // power ramp
   assign base      = (cfg.base_power > (POWER_W-1)'(lfps_pkg::POWER_MAX)) ?
                      (POWER_W-1)'(lfps_pkg::POWER_MAX) : cfg.base_power;
   assign ramp_lift = (base > (POWER_W-1)'(lfps_pkg::RAMP_START) &&
                       ramp_ff < (POWER_W-1)'(lfps_pkg::RAMP_START)) ?
                      (POWER_W-1)'(lfps_pkg::RAMP_START) : ramp_ff;
   assign ramp_step = {1'b0, ramp_lift} + POWER_W'(RAMP_STEP);
   assign ramp_next = (base > ramp_ff) ?
                      ((ramp_step > {1'b0, base}) ? base : ramp_step[POWER_W-2:0]) : base;

   // share of ramp power left on the slowed side
   assign scale_k = (steer_ff > 0) ?
                    ((POWER_W+1)'(lfps_pkg::POWER_MAX) - (POWER_W+1)'(steer_ff)) :
                    ((POWER_W+1)'(lfps_pkg::POWER_MAX) + (POWER_W+1)'(steer_ff));

   // shared multiplier operand select
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      unique case (ctrl.op)
         lfps_pkg::OP_MUL_P: begin
            mul_a = cfg.prop_gain;
            mul_b = MULB_W'(err_ff);
         end
         lfps_pkg::OP_MUL_I: begin
            mul_a = cfg.integ_gain;
            mul_b = mean8;
         end
         lfps_pkg::OP_MUL_D: begin
            mul_a = cfg.deriv_gain;
            mul_b = MULB_W'(diff);
         end
         lfps_pkg::OP_MUL_PWR: begin
            mul_a = MULA_W'({1'b0, ramp_ff});
            mul_b = MULB_W'(scale_k);
         end
         lfps_pkg::OP_MUL_RCP: begin
            mul_a = MULA_W'(lfps_pkg::RECIP_100);
            mul_b = $signed(prod_ff[MULB_W-1:0]);
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // datapath register updates per operation
   always_comb begin
      err_in     = err_ff;
      prev_in    = prev_ff;
      wptr_in    = wptr_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      neg_in     = neg_ff;
      acc_in     = acc_ff;
      steer_in   = steer_ff;
      ramp_in    = ramp_ff;
      hist_we    = 1'b0;
      hist_wdata = err_ff;
      prod_in    = mul_en ? mul_p : prod_ff;
      unique case (ctrl.op)
         lfps_pkg::OP_ERR: begin
            err_in = err_calc;
         end
         lfps_pkg::OP_PUSH: begin
            hist_we  = 1'b1;
            wptr_in  = wptr_next;
            count_in = full ? count_ff : count_ff + CNT_W'(1);
            sum_in   = sum_ff + SUM_W'(err_ff) - oldest_term;
         end
         lfps_pkg::OP_DIV_INIT: begin
            neg_in = sum_ff[SUM_W-1];
         end
         lfps_pkg::OP_MUL_P: begin
            acc_in = '0;
         end
         lfps_pkg::OP_MUL_I: begin
            acc_in = acc_ff + prod_sh;
         end
         lfps_pkg::OP_MUL_D: begin
            acc_in = acc_ff + prod_ext;
         end
         lfps_pkg::OP_ACC_D: begin
            acc_in = acc_ff + prod_sh;
         end
         lfps_pkg::OP_STEER: begin
            prev_in = err_ff;
            ramp_in = ramp_next;
            if (steer_sum > SQ_W'(lfps_pkg::STEER_LIMIT)) begin
               steer_in = POWER_W'(lfps_pkg::STEER_LIMIT);
            end else if (steer_sum < -SQ_W'(lfps_pkg::STEER_LIMIT)) begin
               steer_in = -POWER_W'(lfps_pkg::STEER_LIMIT);
            end else begin
               steer_in = steer_sum[POWER_W-1:0];
            end
         end
         lfps_pkg::OP_CLEAR: begin
            hist_we    = 1'b1;
            hist_wdata = ERR_W'(cfg.light_center);
            wptr_in    = wptr_next;
            count_in   = CNT_W'(1);
            sum_in     = SUM_W'(cfg.light_center);
            prev_in    = ERR_W'(cfg.light_center);
         end
         lfps_pkg::OP_STOP: begin
            ramp_in = '0;
         end
         default: begin
         end
      endcase
   end

   // result powers
   assign scaled_pwr  = $signed({1'b0,
                        prod_ff[lfps_pkg::RECIP_SHIFT+POWER_W-2:lfps_pkg::RECIP_SHIFT]});
   assign ramp_pwr    = $signed({1'b0, ramp_ff});
   assign left_power  = (ctrl.op == lfps_pkg::OP_STOP) ? '0 :
                        ((steer_ff > 0) ? ramp_pwr : scaled_pwr);
   assign right_power = (ctrl.op == lfps_pkg::OP_STOP) ? '0 :
                        ((steer_ff > 0) ? scaled_pwr : ramp_pwr);

   // state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         prev_ff  <= '0;
         ramp_ff  <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         prev_ff  <= prev_in;
         ramp_ff  <= ramp_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         light_ff <= reflect_light;
      end
      err_ff   <= err_in;
      neg_ff   <= neg_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      steer_ff <= steer_in;
   end

   // error history memory
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist[wptr_ff] <= hist_wdata;
      end
      if (ctrl.op == lfps_pkg::OP_ERR) begin
         oldest_ff <= hist[wptr_ff];
      end
   end

endmodule

### rtl/lfps_sequencer.sv
`timescale 1ns / 1ps

module lfps_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  lfps_pkg::seq_cond_type cond,
   output lfps_pkg::ucode_type    ctrl,
   output logic                   idle
);

   logic [lfps_pkg::STEP_W-1:0] step_ff, step_in;
   logic [lfps_pkg::STEP_W-1:0] step_inc;

   assign ctrl     = lfps_pkg::microcode_rom(step_ff);
   assign idle     = (step_ff == lfps_pkg::STEP_IDLE);
   assign step_inc = step_ff + lfps_pkg::STEP_W'(1);

   // branch resolution
   always_comb begin
      step_in = step_ff;
      unique case (ctrl.cond)
         lfps_pkg::C_NEXT: begin
            step_in = step_inc;
         end
         lfps_pkg::C_GOTO: begin
            step_in = ctrl.target;
         end
         lfps_pkg::C_DISPATCH: begin
            if (cond.accept) begin
               unique case (cond.action)
                  lfps_pkg::ACT_SAMPLE: step_in = lfps_pkg::STEP_ERR;
                  lfps_pkg::ACT_CLEAR:  step_in = lfps_pkg::STEP_CLEAR;
                  lfps_pkg::ACT_STOP:   step_in = lfps_pkg::STEP_STOP;
                  default:              step_in = ctrl.target;
               endcase
            end
         end
         lfps_pkg::C_LOOP_DIV: begin
            step_in = cond.div_busy ? step_ff : step_inc;
         end
         lfps_pkg::C_WAIT_OUT: begin
            step_in = cond.out_free ? ctrl.target : step_ff;
         end
         default: begin
            step_in = lfps_pkg::STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= lfps_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### rtl/lfps_checker.sv
`timescale 1ns / 1ps

module lfps_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [lfps_pkg::ACTION_W-1:0]       req_action,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [lfps_pkg::POWER_W-1:0] rsp_left_power,
   input logic signed [lfps_pkg::POWER_W-1:0] rsp_right_power
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_power) &&
                                  $stable(rsp_right_power))
      else $error("stalled result changed");

   // any defined action keeps the input closed in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_action == lfps_pkg::ACT_SAMPLE || req_action == lfps_pkg::ACT_CLEAR ||
       req_action == lfps_pkg::ACT_STOP) |=> !req_ready)
      else $error("input taken while a transaction is in work");

   // stop into an empty output register yields a result with zero powers
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == lfps_pkg::ACT_STOP && !rsp_valid |->
      ##2 (rsp_valid && rsp_left_power == '0 && rsp_right_power == '0))
      else $error("stop result missing or nonzero");

   // powers stay within the motor range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_power >= -8'sd100 && rsp_left_power <= 8'sd100 &&
                     rsp_right_power >= -8'sd100 && rsp_right_power <= 8'sd100))
      else $error("motor power out of range");

endmodule

bind line_follow_pid_steering_top lfps_checker u_lfps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_action      (req_bus.action),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_left_power  (rsp_bus.left_power),
   .rsp_right_power (rsp_bus.right_power)
);
